[hw/rtl/srm_pkg.sv]
// Package for the serial response matcher.
// Holds the operation and status codes, register indexes, limits and shared structs.
// No dependencies; every other file of the block imports it.
`default_nettype none

package srm_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int DATA_MAX    = 255;

	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	// Bit positions of the result fields inside m_tdata
	localparam int TD_BYTE_LSB   = 0;
	localparam int TD_INDEX_LSB  = 8;
	localparam int TD_PREFIX_BIT = 16;
	localparam int TD_STATUS_LSB = 17;
	localparam int TD_WIDTH      = 24;

	typedef enum logic [1:0] {
		OP_ARM  = 2'd0,
		OP_BYTE = 2'd1,
		OP_TICK = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_WAIT    = 2'd0,
		ST_SUCCESS = 2'd1,
		ST_TIMEOUT = 2'd2,
		ST_UNUSED  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_PATTERN_LENGTH = 3'd2,
		REG_DATA_LENGTH    = 3'd3,
		REG_OPEN_ENDED     = 3'd4,
		REG_TIMEOUT_MS     = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [63:0] pattern_low;
		logic [63:0] pattern_high;
		logic [4:0]  pattern_length;
		logic [7:0]  data_length;
		logic        open_ended;
		logic [15:0] timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] data_byte;
		logic [7:0] data_index;
		logic       prefix_matched;
		status_t    status;
	} result_t;

endpackage

`default_nettype wire

[hw/rtl/srm_regs.sv]
// Configuration register file of the serial response matcher.
// Decodes the write channel into the cfg_t struct; depends on srm_pkg.
`default_nettype none

module srm_regs
	import srm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [63:0] wr_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_low    <= '0;
			cfg_q.pattern_high   <= '0;
			cfg_q.pattern_length <= '0;
			cfg_q.data_length    <= '0;
			cfg_q.open_ended     <= 1'b0;
			cfg_q.timeout_ms     <= TIMEOUT_RESET;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_PATTERN_LOW:    cfg_q.pattern_low    <= wr_data;
				REG_PATTERN_HIGH:   cfg_q.pattern_high   <= wr_data;
				REG_PATTERN_LENGTH: cfg_q.pattern_length <= wr_data[4:0];
				REG_DATA_LENGTH:    cfg_q.data_length    <= wr_data[7:0];
				REG_OPEN_ENDED:     cfg_q.open_ended     <= wr_data[0];
				REG_TIMEOUT_MS:     cfg_q.timeout_ms     <= wr_data[15:0];
				default: ; // unmapped index: drop the write
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/srm_core.sv]
// Match and capture state of the serial response matcher.
// Holds the wait state and computes one result per step; depends on srm_pkg.
`default_nettype none

module srm_core
	import srm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       step,
	input  wire op_t        op,
	input  wire logic [7:0] rx_byte,
	output result_t         result
);

	localparam logic [4:0] PLEN_MAX = 5'(PATTERN_MAX);
	localparam logic [7:0] DLEN_MAX = 8'(DATA_MAX);

	logic [4:0]  match_count_q, match_n;
	logic [7:0]  data_count_q, data_n;
	logic [15:0] ticks_left_q, ticks_n;
	logic        active_q, active_n;
	status_t     outcome_q, outcome_n;
	logic        armed_q, armed_n;

	logic [4:0]   eff_plen;
	logic [7:0]   eff_dlen;
	logic [127:0] pattern;
	logic [7:0]   exp_char;
	logic         matched_now;
	logic         capture;

	assign eff_plen    = (cfg.pattern_length > PLEN_MAX) ? PLEN_MAX : cfg.pattern_length;
	assign eff_dlen    = (cfg.data_length > DLEN_MAX) ? DLEN_MAX : cfg.data_length;
	assign pattern     = {cfg.pattern_high, cfg.pattern_low};
	assign exp_char    = pattern[{match_count_q[3:0], 3'b000} +: 8];
	assign matched_now = (match_count_q >= eff_plen);

	always_comb begin
		match_n   = match_count_q;
		data_n    = data_count_q;
		ticks_n   = ticks_left_q;
		active_n  = active_q;
		outcome_n = outcome_q;
		armed_n   = armed_q;
		capture   = 1'b0;

		case (op)
			OP_ARM: begin
				match_n   = '0;
				data_n    = '0;
				ticks_n   = cfg.timeout_ms;
				outcome_n = ST_WAIT;
				active_n  = 1'b1;
				armed_n   = 1'b1;
				// empty pattern, no data and not open-ended: done at once
				if (!cfg.open_ended && eff_plen == '0 && eff_dlen == '0) begin
					active_n  = 1'b0;
					outcome_n = ST_SUCCESS;
				end
			end
			OP_BYTE: begin
				if (active_q) begin
					if (!matched_now) begin
						if (exp_char == rx_byte)
							match_n = match_count_q + 5'd1;
					end else if (cfg.open_ended) begin
						capture = 1'b1;
						if (data_count_q < DLEN_MAX)
							data_n = data_count_q + 8'd1;
					end else if (data_count_q < eff_dlen) begin
						capture = 1'b1;
						data_n  = data_count_q + 8'd1;
					end
					if (!cfg.open_ended && match_n >= eff_plen && data_n >= eff_dlen) begin
						active_n  = 1'b0;
						outcome_n = ST_SUCCESS;
					end
				end
			end
			OP_TICK: begin
				if (active_q) begin
					if (ticks_left_q != '0)
						ticks_n = ticks_left_q - 16'd1;
					if (ticks_n == '0) begin
						active_n  = 1'b0;
						outcome_n = (cfg.open_ended && matched_now) ? ST_SUCCESS : ST_TIMEOUT;
					end
				end
			end
			default: ; // unused code: no state change
		endcase

		result.data_valid     = capture;
		result.data_byte      = capture ? rx_byte : 8'd0;
		result.data_index     = capture ? data_count_q : 8'd0;
		result.prefix_matched = armed_n && (match_n >= eff_plen);
		result.status         = outcome_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_count_q <= '0;
			data_count_q  <= '0;
			ticks_left_q  <= '0;
			active_q      <= 1'b0;
			outcome_q     <= ST_WAIT;
			armed_q       <= 1'b0;
		end else if (step) begin
			match_count_q <= match_n;
			data_count_q  <= data_n;
			ticks_left_q  <= ticks_n;
			active_q      <= active_n;
			outcome_q     <= outcome_n;
			armed_q       <= armed_n;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/serial_response_matcher.sv]
// Top level of the serial response matcher: stream ports, input and result registers.
// Instantiates srm_regs and srm_core; depends on srm_pkg.
//
//   channel   direction  payload                                      handshake
//   s_*       in         tuser: operation; tdata: rx_byte             tvalid/tready
//   m_*       out        tuser: data_valid; tdata: byte,index,flags   tvalid/tready
//   cfg_*     in         cfg_index, cfg_data (64 bit)                 cfg_valid/cfg_ready
//
// Each transaction passes through the input register (_s1) and then the result register
// (_s2); throughput is one item per cycle while m_tready does not stall.
// The match/capture state updates in the same cycle the item moves from _s1 to _s2.
// A stalled m_tready holds the result register, then the input register, then s_tready.
// arst_n clears all control state; configuration returns to its reset values.
// cfg_ready is always high.
`default_nettype none

module serial_response_matcher
	import srm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input stream
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,   // [7:0] rx_byte
	input  wire logic [1:0]          s_tuser,   // [1:0] operation
	// result stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [TD_WIDTH-1:0]      m_tdata,   // [7:0] data_byte, [15:8] data_index,
	                                            // [16] prefix_matched, [18:17] status
	output logic                     m_tuser,   // [0] data_valid
	// configuration writes
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [63:0]         cfg_data
);

	cfg_t    cfg;
	result_t core_result;

	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] byte_s1;

	logic       valid_s2;
	result_t    res_s2;

	logic       adv_s2;
	logic       adv_s1;

	// Result register is free when empty or being drained this cycle
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	assign cfg_ready = 1'b1;

	srm_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Input register: capture a transaction whenever there is room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= op_t'(s_tuser);
			byte_s1 <= s_tdata;
		end
	end

	// State advances only when the item actually moves on to the result register
	srm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (adv_s1),
		.op      (op_s1),
		.rx_byte (byte_s1),
		.result  (core_result)
	);

	// Result register: hold while the downstream side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			res_s2 <= core_result;
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.data_valid;
	assign m_tdata  = {5'd0, res_s2.status, res_s2.prefix_matched,
	                   res_s2.data_index, res_s2.data_byte};

endmodule

`default_nettype wire

[hw/rtl/srm_checker.sv]
// Port-level checks for the serial response matcher, bound to the top level.
// Depends on srm_pkg for the result field positions.
`default_nettype none

module srm_checker
	import srm_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [TD_WIDTH-1:0] m_tdata,
	input wire logic                m_tuser
);

	logic [1:0] st;
	logic       pfx;
	logic [7:0] idx;
	logic [7:0] dbyte;

	assign st    = m_tdata[TD_STATUS_LSB +: 2];
	assign pfx   = m_tdata[TD_PREFIX_BIT];
	assign idx   = m_tdata[TD_INDEX_LSB +: 8];
	assign dbyte = m_tdata[TD_BYTE_LSB +: 8];

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Input backpressure only comes from a stalled full result register
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("s_tready low without output stall");

	// Captured data only follows a full match and never comes with a timeout
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> pfx && st != ST_TIMEOUT && st != ST_UNUSED)
		else $error("data captured without match or with failure");

	// Non-data results carry zero byte and index
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> dbyte == 8'd0 && idx == 8'd0)
		else $error("non-data result carries data fields");

endmodule

bind serial_response_matcher srm_checker u_srm_checker (.*);

`default_nettype wire
